// ===== src/door_motor_relay_sequencer_defines.svh =====
// Assertion helpers for the door relay sequencer.
// Each check samples on clk and is held off while rst_n is low.
`ifndef DOOR_MOTOR_RELAY_SEQUENCER_DEFINES_SVH
`define DOOR_MOTOR_RELAY_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define DMRS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dmrs check failed");
`define DMRS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmrs check failed");
`define DMRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmrs check failed");
`else
`define DMRS_ASSERT_ALWAYS(lbl, cond)
`define DMRS_ASSERT_SAME(lbl, ante, cons)
`define DMRS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/dmrs_pkg.sv =====
`default_nettype none

package dmrs_pkg;

    localparam int MAX_DOORS = 4;
    localparam int DOOR_W    = 2;
    localparam int CNT_W     = 8;
    localparam int ST_W      = 5;
    localparam int WORD_W    = 16;

    // Result kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SETTLE = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Door status bit positions
    localparam int ST_OPEN    = 0;
    localparam int ST_CLOSED  = 1;
    localparam int ST_OPENING = 2;
    localparam int ST_CLOSING = 3;
    localparam int ST_STOPPED = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Timeout register reset values, door 0 first
    localparam logic [CNT_W-1:0] TIMEOUT_RST [MAX_DOORS] = '{8'd180, 8'd7, 8'd7, 8'd1};

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_OPEN   = 6'b000010,
        S_CLOSE  = 6'b000100,
        S_ACT    = 6'b001000,
        S_STOP   = 6'b010000,
        S_STATUS = 6'b100000
    } state_t;

    // Decision from the shared run evaluator
    typedef struct packed {
        logic             run;        // run continues this tick
        logic             finish;     // run ends: relays off
        logic             timed_out;  // ended because count passed timeout
        logic             start;      // first tick of run: emit direction words
        logic [CNT_W-1:0] count_next;
    } step_res_t;

    function automatic logic [WORD_W-1:0] activate_word(input logic [DOOR_W-1:0] door);
        logic [WORD_W-1:0] w;
        case (door)
            2'd0:    w = 16'h0001;
            2'd1:    w = 16'h0008;
            2'd2:    w = 16'h0100;
            2'd3:    w = 16'h1000;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

    // Direction relays; opening leaves them released
    function automatic logic [WORD_W-1:0] dir_word(input logic [DOOR_W-1:0] door,
                                                   input logic is_close);
        logic [WORD_W-1:0] w;
        case (door)
            2'd0:    w = 16'h0006;
            2'd1:    w = 16'h0030;
            2'd2:    w = 16'h0600;
            2'd3:    w = 16'h6000;
            default: w = 16'h0000;
        endcase
        return is_close ? w : 16'h0000;
    endfunction

endpackage

`default_nettype wire

// ===== src/dmrs_step_unit.sv =====
`default_nettype none

// Shared run evaluator: timeout compare and saturating tick count,
// used for every door and both directions in turn.
module dmrs_step_unit
    import dmrs_pkg::*;
(
    input  wire logic             latched,
    input  wire logic             switch_hit,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic [CNT_W-1:0] timeout,
    output step_res_t             res
);

    logic over;
    logic [CNT_W-1:0] count_inc;

    assign over      = count > timeout;
    assign count_inc = (count == CNT_MAX) ? CNT_MAX : count + CNT_W'(1);

    always_comb
    begin
        res.finish     = latched && (switch_hit || over);
        res.timed_out  = latched && over;
        res.run        = latched && !switch_hit && !over;
        res.start      = res.run && (count == '0);
        res.count_next = res.run ? count_inc : '0;
    end

endmodule

`default_nettype wire

// ===== src/door_motor_relay_sequencer.sv =====
// Sequence: a tick steps through open, close and stop for each present door
// (plus an activate step per run start for the second relay word), then status.
// A new tick is taken only in idle, once the status result has been loaded;
// result stalls hold the sequence.
// Reset: latches and tick counts cleared, timeouts 180/7/7/1, no result.
`default_nettype none

`include "door_motor_relay_sequencer_defines.svh"

module door_motor_relay_sequencer
    import dmrs_pkg::*;
#(
    parameter int NUM_DOORS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // tick requests
    input  wire logic        tick_valid,
    output logic             tick_ready,
    input  wire logic [7:0]  switch_bits,
    input  wire logic [3:0]  open_request,
    input  wire logic [3:0]  close_request,
    input  wire logic [3:0]  stop_request,
    // results
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       kind,
    output logic [15:0]      relay_word,
    output logic [4:0]       status_door0,
    output logic [4:0]       status_door1,
    output logic [4:0]       status_door2,
    output logic [4:0]       status_door3,
    output logic [3:0]       pending_open,
    output logic [3:0]       pending_close,
    output logic [3:0]       open_timed_out,
    output logic [3:0]       close_timed_out,
    output logic             last
);

    localparam logic [MAX_DOORS-1:0] DOOR_MASK = MAX_DOORS'((1 << NUM_DOORS) - 1);
    localparam logic [DOOR_W-1:0]    LAST_DOOR = DOOR_W'(NUM_DOORS - 1);

    state_t state_reg, state_next;
    logic [DOOR_W-1:0]    door_reg, door_next;
    logic                 dir_reg, dir_next;
    logic [7:0]           sw_reg;
    logic [MAX_DOORS-1:0] stop_reg;
    logic [MAX_DOORS-1:0] open_latch_reg, open_latch_next;
    logic [MAX_DOORS-1:0] close_latch_reg, close_latch_next;
    logic [MAX_DOORS-1:0] open_to_reg, open_to_next;
    logic [MAX_DOORS-1:0] close_to_reg, close_to_next;
    logic [CNT_W-1:0]     open_cnt_reg [MAX_DOORS];
    logic [CNT_W-1:0]     close_cnt_reg [MAX_DOORS];
    logic [CNT_W-1:0]     timeout_reg [MAX_DOORS];
    logic [ST_W-1:0]      status_reg [MAX_DOORS];

    // output register
    logic                 res_valid_reg;
    logic [1:0]           kind_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [ST_W-1:0]      st_out_reg [MAX_DOORS];
    logic [MAX_DOORS-1:0] pend_open_reg, pend_close_reg, otd_reg, ctd_reg;
    logic                 last_reg;

    // shared unit hookup
    logic                 unit_close;
    logic                 unit_latched;
    logic                 unit_switch;
    logic [CNT_W-1:0]     unit_count;
    step_res_t            step;

    logic                 can_load;
    logic                 tick_take;
    logic                 load_en;
    logic                 load_status;
    logic [1:0]           load_kind;
    logic [WORD_W-1:0]    load_word;
    logic                 cnt_we;
    logic                 stop_clear;
    logic                 st_we;
    logic [ST_W-1:0]      st_wdata;
    logic [ST_W-1:0]      st_cur;

    assign cfg_ready  = 1'b1;
    assign tick_ready = (state_reg == S_IDLE);
    assign tick_take  = tick_valid && tick_ready;
    assign can_load   = !res_valid_reg || result_ready;

    // Operand select for the evaluator
    assign unit_close   = (state_reg == S_CLOSE);
    assign unit_latched = unit_close ? close_latch_reg[door_reg] : open_latch_reg[door_reg];
    assign unit_switch  = sw_reg[{door_reg, unit_close}];
    assign unit_count   = unit_close ? close_cnt_reg[door_reg] : open_cnt_reg[door_reg];
    assign st_cur       = status_reg[door_reg];

    dmrs_step_unit u_step (
        .latched    (unit_latched),
        .switch_hit (unit_switch),
        .count      (unit_count),
        .timeout    (timeout_reg[door_reg]),
        .res        (step)
    );

    // Sequencer: per door open run, close run, stop, then status
    always_comb
    begin
        state_next       = state_reg;
        door_next        = door_reg;
        dir_next         = dir_reg;
        open_latch_next  = open_latch_reg;
        close_latch_next = close_latch_reg;
        open_to_next     = open_to_reg;
        close_to_next    = close_to_reg;
        load_en          = 1'b0;
        load_status      = 1'b0;
        load_kind        = KIND_WRITE;
        load_word        = '0;
        cnt_we           = 1'b0;
        stop_clear       = 1'b0;
        st_we            = 1'b0;
        st_wdata         = st_cur;

        case (state_reg)
            S_IDLE:
            begin
                if (tick_take)
                begin
                    open_latch_next  = (open_latch_reg | open_request) & DOOR_MASK;
                    close_latch_next = (close_latch_reg | close_request) & DOOR_MASK;
                    open_to_next     = '0;
                    close_to_next    = '0;
                    door_next        = '0;
                    state_next       = S_OPEN;
                end
            end
            S_OPEN, S_CLOSE:
            begin
                if (can_load || !(step.finish || step.start))
                begin
                    cnt_we = 1'b1;
                    st_we  = 1'b1;
                    if (unit_close)
                    begin
                        st_wdata[ST_CLOSING] = step.run;
                    end
                    else
                    begin
                        st_wdata              = '0;
                        st_wdata[ST_OPEN]     = sw_reg[{door_reg, 1'b0}];
                        st_wdata[ST_CLOSED]   = sw_reg[{door_reg, 1'b1}];
                        st_wdata[ST_OPENING]  = step.run;
                    end
                    if (step.finish)
                    begin
                        load_en = 1'b1;
                        if (unit_close)
                        begin
                            close_latch_next[door_reg] = 1'b0;
                            close_to_next[door_reg]    = close_to_reg[door_reg]
                                                         | step.timed_out;
                        end
                        else
                        begin
                            open_latch_next[door_reg] = 1'b0;
                            open_to_next[door_reg]    = open_to_reg[door_reg]
                                                        | step.timed_out;
                        end
                    end
                    if (step.start)
                    begin
                        load_en    = 1'b1;
                        load_kind  = KIND_SETTLE;
                        load_word  = dir_word(door_reg, unit_close);
                        dir_next   = unit_close;
                        state_next = S_ACT;
                    end
                    else
                    begin
                        state_next = unit_close ? S_STOP : S_CLOSE;
                    end
                end
            end
            S_ACT:
            begin
                if (can_load)
                begin
                    load_en    = 1'b1;
                    load_word  = activate_word(door_reg) | dir_word(door_reg, dir_reg);
                    state_next = dir_reg ? S_STOP : S_CLOSE;
                end
            end
            S_STOP:
            begin
                if (can_load || !stop_reg[door_reg])
                begin
                    if (stop_reg[door_reg])
                    begin
                        load_en                    = 1'b1;
                        stop_clear                 = 1'b1;
                        st_we                      = 1'b1;
                        st_wdata[ST_OPENING]       = 1'b0;
                        st_wdata[ST_CLOSING]       = 1'b0;
                        st_wdata[ST_STOPPED]       = 1'b1;
                        open_latch_next[door_reg]  = 1'b0;
                        close_latch_next[door_reg] = 1'b0;
                    end
                    if (door_reg == LAST_DOOR)
                    begin
                        state_next = S_STATUS;
                    end
                    else
                    begin
                        door_next  = door_reg + DOOR_W'(1);
                        state_next = S_OPEN;
                    end
                end
            end
            S_STATUS:
            begin
                if (can_load)
                begin
                    load_en     = 1'b1;
                    load_status = 1'b1;
                    load_kind   = KIND_STATUS;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, latches, counters, timeouts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            door_reg        <= '0;
            dir_reg         <= 1'b0;
            open_latch_reg  <= '0;
            close_latch_reg <= '0;
            open_to_reg     <= '0;
            close_to_reg    <= '0;
            res_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_DOORS; i++)
            begin
                open_cnt_reg[i]  <= '0;
                close_cnt_reg[i] <= '0;
                timeout_reg[i]   <= TIMEOUT_RST[i];
            end
        end
        else
        begin
            state_reg       <= state_next;
            door_reg        <= door_next;
            dir_reg         <= dir_next;
            open_latch_reg  <= open_latch_next;
            close_latch_reg <= close_latch_next;
            open_to_reg     <= open_to_next;
            close_to_reg    <= close_to_next;
            if (load_en)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready && !cfg_index[2])
                timeout_reg[cfg_index[1:0]] <= cfg_data;
            if (cnt_we && unit_close)
                close_cnt_reg[door_reg] <= step.count_next;
            else if (cnt_we)
                open_cnt_reg[door_reg] <= step.count_next;
            if (stop_clear)
            begin
                open_cnt_reg[door_reg]  <= '0;
                close_cnt_reg[door_reg] <= '0;
            end
        end
    end

    // Tick capture and per-door status
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            sw_reg   <= switch_bits;
            stop_reg <= stop_request & DOOR_MASK;
            for (int i = 0; i < MAX_DOORS; i++)
                status_reg[i] <= '0;
        end
        else if (st_we)
        begin
            status_reg[door_reg] <= st_wdata;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            kind_reg <= load_kind;
            word_reg <= load_word;
            last_reg <= load_status;
            for (int i = 0; i < MAX_DOORS; i++)
                st_out_reg[i] <= load_status ? status_reg[i] : '0;
            pend_open_reg  <= load_status ? open_latch_reg : '0;
            pend_close_reg <= load_status ? close_latch_reg : '0;
            otd_reg        <= load_status ? open_to_reg : '0;
            ctd_reg        <= load_status ? close_to_reg : '0;
        end
    end

    assign result_valid    = res_valid_reg;
    assign kind            = kind_reg;
    assign relay_word      = word_reg;
    assign status_door0    = st_out_reg[0];
    assign status_door1    = st_out_reg[1];
    assign status_door2    = st_out_reg[2];
    assign status_door3    = st_out_reg[3];
    assign pending_open    = pend_open_reg;
    assign pending_close   = pend_close_reg;
    assign open_timed_out  = otd_reg;
    assign close_timed_out = ctd_reg;
    assign last            = last_reg;

    // Checks
    `DMRS_ASSERT_ALWAYS(a_no_absent_latch,
        ((open_latch_reg | close_latch_reg) & ~DOOR_MASK) == '0)
    `DMRS_ASSERT_SAME(a_last_on_status, result_valid, last == (kind == KIND_STATUS))
    `DMRS_ASSERT_NEXT(a_tick_starts_door0, tick_take,
        state_reg == S_OPEN && door_reg == '0)
    `DMRS_ASSERT_NEXT(a_status_loads_last, state_reg == S_STATUS && can_load,
        result_valid && last && state_reg == S_IDLE)

endmodule

`default_nettype wire
